### design/apsp_pkg.sv
`default_nettype none

package apsp_pkg;

   localparam int MAX_NODES_DEFAULT = 16;
   localparam int DIST_W            = 15;
   localparam int NODE_W            = 4;
   localparam int COUNT_W           = 5;
   localparam int CSR_INDEX_W       = 4;
   localparam int CSR_DATA_W        = 15;

   localparam logic [COUNT_W-1:0] COUNT_RESET   = COUNT_W'(16);
   localparam logic [DIST_W-1:0]  NO_EDGE_RESET = DIST_W'(10000);

   localparam logic [1:0] CMD_LOAD    = 2'd0;
   localparam logic [1:0] CMD_COMPUTE = 2'd1;
   localparam logic [1:0] CMD_READ    = 2'd2;

   localparam logic [CSR_INDEX_W-1:0] REG_NODE_COUNT = CSR_INDEX_W'(0);
   localparam logic [CSR_INDEX_W-1:0] REG_NO_EDGE    = CSR_INDEX_W'(1);

   localparam logic KIND_READ = 1'b0;
   localparam logic KIND_DONE = 1'b1;

   typedef enum logic [3:0] {
      S_IDLE,
      S_LOAD,
      S_RDA,
      S_RDB,
      S_CINIT,
      S_ROW,
      S_ROWCAP,
      S_LOOP,
      S_DRAIN,
      S_NEXTK,
      S_FIN
   } step_type;

   typedef enum logic [2:0] {
      C_NEXT,
      C_JUMP,
      C_DISPATCH,
      C_J_NOT_LAST,
      C_I_NOT_LAST,
      C_K_NOT_LAST,
      C_N_ZERO
   } cond_type;

   typedef enum logic [1:0] {
      RD_NONE,
      RD_REQ,
      RD_ROW,
      RD_LOOP
   } rd_sel_type;

   typedef struct packed {
      logic       accept;
      rd_sel_type rd_sel;
      logic       wr_load;
      logic       issue;
      logic       retire;
      logic       cap_dik;
      logic       emit_read;
      logic       emit_done;
      logic       wait_out;
      logic       clr_k;
      logic       clr_i;
      logic       clr_j;
      logic       inc_k;
      logic       inc_i;
      logic       inc_j;
      cond_type   cond;
      step_type   target;
   } ctrl_word_type;

   typedef struct packed {
      logic       fire;
      logic [1:0] command;
      logic       j_last;
      logic       i_last;
      logic       k_last;
      logic       n_zero;
      logic       out_busy;
   } seq_status_type;

   typedef struct packed {
      ctrl_word_type word;
      logic          go;
   } seq_ctrl_type;

   function automatic ctrl_word_type ucode(step_type s);
      ctrl_word_type w;
      w        = '0;
      w.rd_sel = RD_NONE;
      w.cond   = C_NEXT;
      w.target = S_IDLE;
      unique case (s)
         S_IDLE: begin
            w.accept = 1'b1;
            w.cond   = C_DISPATCH;
         end
         S_LOAD: begin
            w.wr_load = 1'b1;
            w.cond    = C_JUMP;
         end
         S_RDA: begin
            w.rd_sel = RD_REQ;
         end
         S_RDB: begin
            w.wait_out  = 1'b1;
            w.emit_read = 1'b1;
            w.cond      = C_JUMP;
         end
         S_CINIT: begin
            w.clr_k  = 1'b1;
            w.clr_i  = 1'b1;
            w.cond   = C_N_ZERO;
            w.target = S_FIN;
         end
         S_ROW: begin
            w.rd_sel = RD_ROW;
            w.clr_j  = 1'b1;
         end
         S_ROWCAP: begin
            w.cap_dik = 1'b1;
         end
         S_LOOP: begin
            w.rd_sel = RD_LOOP;
            w.issue  = 1'b1;
            w.retire = 1'b1;
            w.inc_j  = 1'b1;
            w.cond   = C_J_NOT_LAST;
            w.target = S_LOOP;
         end
         S_DRAIN: begin
            w.retire = 1'b1;
            w.inc_i  = 1'b1;
            w.cond   = C_I_NOT_LAST;
            w.target = S_ROW;
         end
         S_NEXTK: begin
            w.inc_k  = 1'b1;
            w.clr_i  = 1'b1;
            w.cond   = C_K_NOT_LAST;
            w.target = S_ROW;
         end
         S_FIN: begin
            w.wait_out  = 1'b1;
            w.emit_done = 1'b1;
            w.cond      = C_JUMP;
         end
         default: begin
            w.cond = C_JUMP;
         end
      endcase
      return w;
   endfunction

endpackage

`default_nettype wire

### design/apsp_if.sv
`default_nettype none

interface apsp_req_if import apsp_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [1:0]        command;
   logic [NODE_W-1:0] row;
   logic [NODE_W-1:0] col;
   logic [DIST_W-1:0] weight;

   modport source (output valid, command, row, col, weight, input ready);
   modport sink   (input valid, command, row, col, weight, output ready);
endinterface

interface apsp_rsp_if import apsp_pkg::*; ();
   logic              valid;
   logic              ready;
   logic              kind;
   logic [DIST_W-1:0] distance;

   modport source (output valid, kind, distance, input ready);
   modport sink   (input valid, kind, distance, output ready);
endinterface

interface apsp_csr_if import apsp_pkg::*; ();
   logic                   valid;
   logic                   ready;
   logic [CSR_INDEX_W-1:0] index;
   logic [CSR_DATA_W-1:0]  data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

### design/all_pairs_shortest_paths.sv
`default_nettype none

// All-pairs shortest paths by Floyd-Warshall over a distance matrix held in a
// two-read, one-write memory. A load request writes one entry (diagonal forced
// to 0, zero weight stored as the no-edge distance); a read request returns
// the entry; a compute request runs a short microprogram that walks k, i and j
// below n = min(node_count, MAX_NODES) and answers with a completion response.
// The inner j loop retires one relaxation per cycle through the memory's two
// read ports and its write port; each row also passes the steps S_ROW and
// S_ROWCAP to fetch the row's pivot entry and S_DRAIN to drain the pipe.
// Entries must be loaded before they are read or computed over, and diagonal
// entries must be loaded. Requests are taken only while the sequencer is idle;
// a finished response waits in an output register without blocking the next
// request from being taken, though a later response waits until it is taken.
module all_pairs_shortest_paths import apsp_pkg::*; #(
   parameter int MAX_NODES = MAX_NODES_DEFAULT
) (
   input  wire logic clock,
   input  wire logic reset,
   apsp_req_if.sink   req_bus,
   apsp_rsp_if.source rsp_bus,
   apsp_csr_if.sink   csr_bus
);

   localparam int AW    = $clog2(MAX_NODES);
   localparam int CW    = $clog2(MAX_NODES + 1);
   localparam int NW    = (CW > COUNT_W) ? CW : COUNT_W;
   localparam int DEPTH = 1 << (2 * AW);

   logic [COUNT_W-1:0] node_count_ff;
   logic [DIST_W-1:0]  no_edge_ff;

   logic [NODE_W-1:0]  rq_row_ff;
   logic [NODE_W-1:0]  rq_col_ff;
   logic [DIST_W-1:0]  rq_weight_ff;
   logic               rq_in_range_ff;

   logic [DIST_W-1:0]  mem [DEPTH];
   logic [DIST_W-1:0]  rd0_ff;
   logic [DIST_W-1:0]  rd1_ff;
   logic [DIST_W-1:0]  dik_ff;

   logic [AW-1:0]      k_ff, k_in;
   logic [AW-1:0]      i_ff, i_in;
   logic [AW-1:0]      j_ff, j_in;
   logic [AW-1:0]      jp_ff;
   logic               pend_ff;

   logic               rsp_valid_ff;
   logic               rsp_kind_ff;
   logic [DIST_W-1:0]  rsp_dist_ff;

   seq_status_type     status;
   seq_ctrl_type       ctrl;
   ctrl_word_type      w;

   logic               fire;
   logic               in_range;
   logic [NW-1:0]      count_ext;
   logic [CW-1:0]      n_act;
   logic               out_busy;

   logic               rd0_en;
   logic               rd1_en;
   logic [2*AW-1:0]    raddr0;
   logic [2*AW-1:0]    raddr1;
   logic               mem_we;
   logic [2*AW-1:0]    waddr;
   logic [DIST_W-1:0]  wdata;
   logic [DIST_W:0]    via;
   logic [DIST_W-1:0]  load_value;

   assign w = ctrl.word;

   assign fire     = req_bus.valid && w.accept;
   assign in_range = ({28'd0, req_bus.row} < 32'(MAX_NODES))
                  && ({28'd0, req_bus.col} < 32'(MAX_NODES));

   assign count_ext = NW'(node_count_ff);
   assign n_act     = (count_ext > NW'(MAX_NODES)) ? CW'(MAX_NODES) : CW'(count_ext);
   assign out_busy  = rsp_valid_ff && !rsp_bus.ready;

   always_comb begin
      status.fire     = fire;
      status.command  = req_bus.command;
      status.j_last   = (CW'(j_ff) + CW'(1)) == n_act;
      status.i_last   = (CW'(i_ff) + CW'(1)) == n_act;
      status.k_last   = (CW'(k_ff) + CW'(1)) == n_act;
      status.n_zero   = n_act == '0;
      status.out_busy = out_busy;
   end

   apsp_sequencer u_seq (
      .clock  (clock),
      .reset  (reset),
      .status (status),
      .ctrl   (ctrl)
   );

   assign req_bus.ready = w.accept;
   assign csr_bus.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         node_count_ff <= COUNT_RESET;
         no_edge_ff    <= NO_EDGE_RESET;
      end else if (csr_bus.valid) begin
         case (csr_bus.index)
            REG_NODE_COUNT: node_count_ff <= csr_bus.data[COUNT_W-1:0];
            REG_NO_EDGE:    no_edge_ff    <= csr_bus.data[DIST_W-1:0];
            default:        ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         rq_row_ff      <= req_bus.row;
         rq_col_ff      <= req_bus.col;
         rq_weight_ff   <= req_bus.weight;
         rq_in_range_ff <= in_range;
      end
   end

   always_comb begin
      rd0_en = 1'b0;
      rd1_en = 1'b0;
      raddr0 = {i_ff, j_ff};
      raddr1 = {k_ff, j_ff};
      case (w.rd_sel)
         RD_REQ: begin
            rd0_en = 1'b1;
            raddr0 = {AW'(rq_row_ff), AW'(rq_col_ff)};
         end
         RD_ROW: begin
            rd0_en = 1'b1;
            raddr0 = {i_ff, k_ff};
         end
         RD_LOOP: begin
            rd0_en = 1'b1;
            rd1_en = 1'b1;
         end
         default: ;
      endcase
   end

   always_comb begin
      if (rq_row_ff == rq_col_ff) begin
         load_value = '0;
      end else if (rq_weight_ff == '0) begin
         load_value = no_edge_ff;
      end else begin
         load_value = rq_weight_ff;
      end
   end

   assign via = {1'b0, dik_ff} + {1'b0, rd1_ff};

   always_comb begin
      mem_we = 1'b0;
      waddr  = {i_ff, jp_ff};
      wdata  = via[DIST_W-1:0];
      if (w.wr_load) begin
         mem_we = rq_in_range_ff;
         waddr  = {AW'(rq_row_ff), AW'(rq_col_ff)};
         wdata  = load_value;
      end else if (w.retire && pend_ff) begin
         mem_we = via < {1'b0, rd0_ff};
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[waddr] <= wdata;
      end
      if (rd0_en) begin
         rd0_ff <= mem[raddr0];
      end
      if (rd1_en) begin
         rd1_ff <= mem[raddr1];
      end
   end

   always_ff @(posedge clock) begin
      if (w.cap_dik) begin
         dik_ff <= rd0_ff;
      end
      if (w.issue) begin
         jp_ff <= j_ff;
      end
   end

   always_comb begin
      k_in = k_ff;
      i_in = i_ff;
      j_in = j_ff;
      if (w.clr_k) begin
         k_in = '0;
      end else if (w.inc_k) begin
         k_in = k_ff + AW'(1);
      end
      if (w.clr_i) begin
         i_in = '0;
      end else if (w.inc_i) begin
         i_in = i_ff + AW'(1);
      end
      if (w.clr_j) begin
         j_in = '0;
      end else if (w.inc_j) begin
         j_in = j_ff + AW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         k_ff    <= '0;
         i_ff    <= '0;
         j_ff    <= '0;
         pend_ff <= 1'b0;
      end else begin
         k_ff    <= k_in;
         i_ff    <= i_in;
         j_ff    <= j_in;
         pend_ff <= w.issue;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (ctrl.go && (w.emit_read || w.emit_done)) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_bus.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.go && w.emit_read) begin
         rsp_kind_ff <= KIND_READ;
         rsp_dist_ff <= rq_in_range_ff ? rd0_ff : '0;
      end else if (ctrl.go && w.emit_done) begin
         rsp_kind_ff <= KIND_DONE;
         rsp_dist_ff <= '0;
      end
   end

   assign rsp_bus.valid    = rsp_valid_ff;
   assign rsp_bus.kind     = rsp_kind_ff;
   assign rsp_bus.distance = rsp_dist_ff;

endmodule

`default_nettype wire

### design/apsp_sequencer.sv
`default_nettype none

module apsp_sequencer import apsp_pkg::*; (
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire seq_status_type status,
   output seq_ctrl_type        ctrl
);

   step_type      step_ff;
   step_type      step_in;
   ctrl_word_type word;
   logic          go;
   step_type      step_next;

   always_comb begin
      word      = ucode(step_ff);
      go        = !(word.wait_out && status.out_busy);
      step_next = step_type'(4'(step_ff) + 4'd1);
      ctrl.word = word;
      ctrl.go   = go;
   end

   always_comb begin
      step_in = step_ff;
      if (go) begin
         unique case (word.cond)
            C_NEXT:       step_in = step_next;
            C_JUMP:       step_in = word.target;
            C_DISPATCH: begin
               if (status.fire) begin
                  case (status.command)
                     CMD_LOAD:    step_in = S_LOAD;
                     CMD_COMPUTE: step_in = S_CINIT;
                     CMD_READ:    step_in = S_RDA;
                     default:     step_in = S_IDLE;
                  endcase
               end
            end
            C_J_NOT_LAST: step_in = status.j_last ? step_next : word.target;
            C_I_NOT_LAST: step_in = status.i_last ? step_next : word.target;
            C_K_NOT_LAST: step_in = status.k_last ? step_next : word.target;
            C_N_ZERO:     step_in = status.n_zero ? word.target : step_next;
            default:      step_in = S_IDLE;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= S_IDLE;
      end else begin
         step_ff <= step_in;
      end
   end

endmodule

`default_nettype wire

### design/apsp_checker.sv
`default_nettype none

module apsp_assertions import apsp_pkg::*; (
   input wire logic              clock,
   input wire logic              reset,
   input wire logic              req_valid,
   input wire logic              req_ready,
   input wire logic [1:0]        req_command,
   input wire logic              rsp_valid,
   input wire logic              rsp_ready,
   input wire logic              rsp_kind,
   input wire logic [DIST_W-1:0] rsp_distance
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_kind) && $stable(rsp_distance))
      else $error("stalled response changed");

   a_done_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_kind == KIND_DONE) |-> rsp_distance == '0)
      else $error("completion response carries a distance");

   a_busy_after_request: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && ((req_command == CMD_LOAD) || (req_command == CMD_COMPUTE)
      || (req_command == CMD_READ)) |=> !req_ready)
      else $error("request taken while previous request is in progress");

   a_reset_clears: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid after reset");

endmodule

bind all_pairs_shortest_paths apsp_assertions u_apsp_assertions (
   .clock        (clock),
   .reset        (reset),
   .req_valid    (req_bus.valid),
   .req_ready    (req_bus.ready),
   .req_command  (req_bus.command),
   .rsp_valid    (rsp_bus.valid),
   .rsp_ready    (rsp_bus.ready),
   .rsp_kind     (rsp_bus.kind),
   .rsp_distance (rsp_bus.distance)
);

`default_nettype wire
